// ===== design/qdd_pkg.sv =====
`timescale 1ns / 1ps

package qdd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_HIGH      = 2'd0;
  localparam logic [1:0] CFG_STEPS_PER_DETENT = 2'd1;

  localparam logic [2:0] STEPS_RESET = 3'd2;

  // Hard ceiling of the 6-bit pending count
  localparam int unsigned HW_MAX_PENDING = 31;

  // Quarter step per {previous_ab, current_ab}
  localparam logic signed [1:0] QUARTER_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic       active_high;
    logic [2:0] steps_per_detent;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        previous_ab;
    logic signed [3:0] quarter_sum;
    logic signed [5:0] pending_count;
  } state_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic take;
  } sample_t;

  typedef struct packed {
    logic signed [5:0] taken_detents;
    logic signed [5:0] pending_detents;
  } result_t;

endpackage

// ===== design/qdd_cfg.sv =====
`timescale 1ns / 1ps

module qdd_cfg import qdd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [2:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ACTIVE_HIGH:      cfg_d.active_high      = cfg_data_i[0];
        CFG_STEPS_PER_DETENT: cfg_d.steps_per_detent = cfg_data_i;
        default:              cfg_d = cfg_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_high      <= 1'b0;
      cfg_q.steps_per_detent <= STEPS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/qdd_step.sv =====
`timescale 1ns / 1ps

module qdd_step import qdd_pkg::*; #(
  parameter int unsigned PENDING_LIMIT = 16
) (
  input  cfg_t    cfg_i,
  input  sample_t sample_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  localparam int unsigned LIM =
    (PENDING_LIMIT > HW_MAX_PENDING) ? HW_MAX_PENDING : PENDING_LIMIT;
  localparam logic signed [5:0] LIM_POS = 6'(LIM);
  localparam logic signed [5:0] LIM_NEG = -6'sd1 * 6'(LIM);

  logic              a, b;
  logic [1:0]        ab;
  logic signed [1:0] q;
  logic signed [4:0] sum_ext;
  logic signed [4:0] spd_pos, spd_neg;
  logic signed [5:0] pending;

  always_comb begin
    a       = (sample_i.pin_a == cfg_i.active_high);
    b       = (sample_i.pin_b == cfg_i.active_high);
    ab      = {a, b};
    q       = QUARTER_TABLE[{state_i.previous_ab, ab}];
    sum_ext = 5'(state_i.quarter_sum) + 5'(q);
    spd_pos = $signed({2'b00, cfg_i.steps_per_detent});
    spd_neg = -spd_pos;

    state_o.previous_ab = ab;
    state_o.quarter_sum = state_i.quarter_sum;
    pending             = state_i.pending_count;

    if (q != 2'sd0) begin
      if (sum_ext >= spd_pos) begin
        if (pending < LIM_POS) pending = pending + 6'sd1;
        state_o.quarter_sum = 4'sd0;
      end else if (sum_ext <= spd_neg) begin
        if (pending > LIM_NEG) pending = pending - 6'sd1;
        state_o.quarter_sum = 4'sd0;
      end else begin
        state_o.quarter_sum = sum_ext[3:0];
      end
    end

    // take drains after the step
    if (sample_i.take) begin
      result_o.taken_detents = pending;
      pending                = 6'sd0;
    end else begin
      result_o.taken_detents = 6'sd0;
    end

    state_o.pending_count    = pending;
    result_o.pending_detents = pending;
  end

endmodule

// ===== design/quadrature_detent_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata[2:0] pin_a, pin_b, take
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata[11:0] taken, pending
// cfg       in   cfg_valid_i/cfg_ready_o          cfg_index_i, cfg_data_i
//
// Two register stages: an input register and a result register, with the
// table lookup, quarter-sum add/compare and pending update in between.
// One beat per cycle sustained while m_axis is ready; a beat passes the input
// register, then the result register. Stalls on m_axis back up through the
// input register, which still takes a beat whenever it drains that same cycle.
// Reset (rst_ni low, async) clears both valid flags, the decoder state and
// the config (active low pins, two quarter steps per detent).

module quadrature_detent_decoder import qdd_pkg::*; #(
  parameter int unsigned PENDING_LIMIT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] pin_a, [1] pin_b, [2] take, [7:3] zero

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [5:0] taken_detents, [11:6] pending_detents

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,      // 0 active_high, 1 steps_per_detent
  input  logic [2:0]  cfg_data_i
);

  cfg_t    cfg;
  sample_t in_q;
  logic    in_valid_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    advance;

  qdd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  qdd_step #(
    .PENDING_LIMIT (PENDING_LIMIT)
  ) u_step (
    .cfg_i    (cfg),
    .sample_i (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // The registered sample moves on when the result slot is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.pin_a <= s_axis_tdata_i[0];
      in_q.pin_b <= s_axis_tdata_i[1];
      in_q.take  <= s_axis_tdata_i[2];
    end
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.pending_detents, res_q.taken_detents};

endmodule
